// ===== sv/dwr_pkg.sv =====
`timescale 1ns / 1ps
package dwr_pkg;

	// Default pool depth (largest range that fits one round)
	localparam int DWR_POOL_DEPTH = 256;

	// Fixed field widths
	localparam int WORD_W = 32;
	localparam int NUM_W  = 8;
	localparam int CNT_W  = 9;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_DRAW_COUNT = 2'd2;

	// Register reset values
	localparam logic [NUM_W-1:0] RANGE_LOW_RST  = 8'd1;
	localparam logic [NUM_W-1:0] RANGE_HIGH_RST = 8'd33;
	localparam logic [CNT_W-1:0] DRAW_COUNT_RST = 9'd6;

endpackage

// ===== sv/dwr_ram.sv =====
`timescale 1ns / 1ps
module dwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/draw_without_replacement_core.sv =====
`timescale 1ns / 1ps
// Draws distinct numbers from [range_low, range_high] without replacement.
// Input channel (in_valid/in_ready) takes one random_word per pick; output
// channel (out_valid/out_ready) returns one transaction per input: the drawn
// number, round_last on the pick that ends a round, or range_error (number 0)
// when the configured range cannot serve a round.
// Registers sit on an APB-style port at byte addresses 0, 4 and 8.
// One item is worked at a time. The pick index is random_word modulo the
// pool size, from a radix-2 divider. The first pick of a round also refills
// the pool RAM, one entry a cycle, in parallel with the divide. The pick
// then reads the RAM and closes the gap, one entry a cycle through the
// single read and write port. in_ready is high while the block is idle.
// The result waits in an output register; the next item may be accepted
// while it waits, and that item stalls at its end until the slot frees.
// Reset clears the round (next input starts a fresh pool), restores the
// register defaults and drops out_valid. The pool RAM is not cleared.
module draw_without_replacement_core
	import dwr_pkg::*;
#(
	parameter int POOL_DEPTH = DWR_POOL_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] random_word,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NUM_W-1:0]  drawn_number,
	output logic              round_last,
	output logic              range_error,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW    = $clog2(POOL_DEPTH);
	localparam int CW    = $clog2(POOL_DEPTH + 1);
	localparam int DCW   = $clog2(WORD_W + 1);
	localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(POOL_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_DIV,
		S_PICK,
		S_SHIFT,
		S_EMIT
	} state_t;

	// Configuration registers
	logic [NUM_W-1:0] range_low_q;
	logic [NUM_W-1:0] range_high_q;
	logic [CNT_W-1:0] draw_count_q;

	// Control and round state
	state_t           state_q;
	logic [CW-1:0]    pool_size_q;
	logic [CNT_W-1:0] picks_done_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    ptr_q;
	logic             err_q;
	logic [NUM_W-1:0] num_q;

	// Divider
	logic [DCW-1:0]    div_cnt_q;
	logic [WORD_W-1:0] div_word_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    rem_shift;

	// Output register
	logic             out_valid_q;
	logic [NUM_W-1:0] drawn_number_q;
	logic             round_last_q;
	logic             range_error_q;

	// RAM port
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [NUM_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [NUM_W-1:0] ram_rdata;

	// Misc combinational
	logic             cfg_wr;
	logic             in_acc;
	logic             fresh;
	logic [CNT_W-1:0] span;
	logic             cfg_bad;
	logic             div_done;
	logic [CW-1:0]    ptr_inc;
	logic             more;
	logic             out_free;
	logic             emit_go;
	logic [CNT_W-1:0] picks_next;
	logic [CW-1:0]    size_next;
	logic             last_pick;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			draw_count_q <= DRAW_COUNT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_RANGE_LOW:  range_low_q  <= pwdata[NUM_W-1:0];
				REG_RANGE_HIGH: range_high_q <= pwdata[NUM_W-1:0];
				REG_DRAW_COUNT: draw_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RANGE_LOW:  prdata = DATA_W'(range_low_q);
			REG_RANGE_HIGH: prdata = DATA_W'(range_high_q);
			REG_DRAW_COUNT: prdata = DATA_W'(draw_count_q);
			default:        prdata = '0;
		endcase
	end

	// Round start checks
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign fresh    = (picks_done_q == '0) || (pool_size_q == '0);
	assign span     = {1'b0, range_high_q} - {1'b0, range_low_q} + CNT_W'(1);
	assign cfg_bad  = (range_low_q > range_high_q) || (draw_count_q == '0)
	                  || (span < draw_count_q) || (span > DEPTH_N);

	// Divider step: restoring, one quotient bit a cycle
	assign div_done  = (div_cnt_q == '0);
	assign rem_shift = {rem_q, div_word_q[WORD_W-1]};

	// Shift pointer and round end
	assign ptr_inc    = ptr_q + CW'(1);
	assign more       = (ptr_inc < pool_size_q);
	assign out_free   = !out_valid_q || out_ready;
	assign emit_go    = (state_q == S_EMIT) && out_free;
	assign picks_next = picks_done_q + CNT_W'(1);
	assign size_next  = pool_size_q - CW'(1);
	assign last_pick  = (picks_next >= draw_count_q) || (size_next == '0);

	// RAM access per state; the gap closes by reading entry ptr+1 while
	// writing entry ptr-1, so the two never touch the same entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(fill_q);
		ram_wdata = range_low_q + NUM_W'(fill_q);
		ram_re    = 1'b0;
		ram_raddr = AW'(ptr_inc);
		case (state_q)
			S_FILL: begin
				ram_we = 1'b1;
			end
			S_DIV: begin
				ram_re    = div_done;
				ram_raddr = AW'(rem_q);
			end
			S_PICK: begin
				ram_re = more;
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(ptr_q - CW'(1));
				ram_wdata = ram_rdata;
				ram_re    = more;
			end
			default: ;
		endcase
	end

	dwr_ram #(
		.WIDTH(NUM_W),
		.DEPTH(POOL_DEPTH)
	) u_pool (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Divider registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (in_acc && !(fresh && cfg_bad)) begin
			div_cnt_q <= DCW'(WORD_W);
		end else if (!div_done) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			div_word_q <= random_word;
			rem_q      <= '0;
			div_q      <= fresh ? span : CNT_W'(pool_size_q);
		end else if (!div_done) begin
			div_word_q <= {div_word_q[WORD_W-2:0], 1'b0};
			if (rem_shift >= {1'b0, div_q}) begin
				rem_q <= CNT_W'(rem_shift - {1'b0, div_q});
			end else begin
				rem_q <= rem_shift[CNT_W-1:0];
			end
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pool_size_q    <= '0;
			picks_done_q   <= '0;
			fill_q         <= '0;
			ptr_q          <= '0;
			err_q          <= 1'b0;
			num_q          <= '0;
			out_valid_q    <= 1'b0;
			drawn_number_q <= '0;
			round_last_q   <= 1'b0;
			range_error_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						err_q <= fresh && cfg_bad;
						if (fresh && cfg_bad) begin
							state_q <= S_EMIT;
						end else if (fresh) begin
							pool_size_q  <= CW'(span);
							picks_done_q <= '0;
							fill_q       <= '0;
							state_q      <= S_FILL;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_FILL: begin
					fill_q <= fill_q + CW'(1);
					if (fill_q == pool_size_q - CW'(1)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ptr_q   <= CW'(rem_q);
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					num_q <= ram_rdata;
					if (more) begin
						ptr_q   <= ptr_inc;
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SHIFT: begin
					if (more) begin
						ptr_q <= ptr_inc;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (err_q) begin
							drawn_number_q <= '0;
							round_last_q   <= 1'b0;
							range_error_q  <= 1'b1;
						end else begin
							drawn_number_q <= num_q;
							round_last_q   <= last_pick;
							range_error_q  <= 1'b0;
							pool_size_q    <= size_next;
							picks_done_q   <= last_pick ? '0 : picks_next;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign drawn_number = drawn_number_q;
	assign round_last   = round_last_q;
	assign range_error  = range_error_q;

	// Checks
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_size_q <= CW'(POOL_DEPTH))
		else $error("pool size beyond pool depth");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> div_done)
		else $error("divider busy while idle");

	a_shift_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (ptr_q < pool_size_q) && (ptr_q != '0))
		else $error("pool shift outside live entries");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (drawn_number == '0) && !round_last)
		else $error("error result carries a number");

endmodule
